@@ rtl/laser_vector_frame_parser_top_macros.svh @@
// Assertion macros for the laser vector frame parser.
// Every macro samples on aclk and is held off while aresetn is low.
`ifndef LASER_VECTOR_FRAME_PARSER_TOP_MACROS_SVH
`define LASER_VECTOR_FRAME_PARSER_TOP_MACROS_SVH

// A property that must hold in the cycle where its condition is true.
`define LVFP_ASSERT_NOW(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (prop)) \
        else $error(msg);

// A property that must hold in the cycle after its condition is true.
`define LVFP_ASSERT_NEXT(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (prop)) \
        else $error(msg);

`endif

@@ rtl/lvfp_pkg.sv @@
// Shared types, codes and the default palette for the laser vector frame parser.
// No dependencies; used by lvfp_palette and laser_vector_frame_parser_top.
package lvfp_pkg;

    localparam int PALETTE_DEPTH_DEF = 256;
    localparam int PAL_ADDR_W        = 8;
    localparam int COLOUR_W          = 24;
    localparam int DEFAULT_COLOURS   = 64;

    localparam logic [31:0] TAG_WORD  = 32'h494C4441;
    localparam int          BLANK_BIT = 6;

    localparam logic [1:0] KIND_POINT   = 2'd0;
    localparam logic [1:0] KIND_END     = 2'd1;
    localparam logic [1:0] KIND_BAD_TAG = 2'd2;
    localparam logic [1:0] KIND_BAD_FMT = 2'd3;

    localparam logic [7:0] FMT_3D_IDX  = 8'd0;
    localparam logic [7:0] FMT_2D_IDX  = 8'd1;
    localparam logic [7:0] FMT_PALETTE = 8'd2;
    localparam logic [7:0] FMT_3D_TRUE = 8'd4;
    localparam logic [7:0] FMT_2D_TRUE = 8'd5;

    typedef struct packed {
        logic                  en;
        logic [PAL_ADDR_W-1:0] addr;
        logic [COLOUR_W-1:0]   data;
    } pal_wr_t;

    function automatic logic [COLOUR_W-1:0] dflt_colour(input logic [5:0] i);
        logic [COLOUR_W-1:0] c;
        case (i)
            6'd0:  c = 24'hFF0000;  6'd1:  c = 24'hFF1000;  6'd2:  c = 24'hFF2000;
            6'd3:  c = 24'hFF3000;  6'd4:  c = 24'hFF4000;  6'd5:  c = 24'hFF5000;
            6'd6:  c = 24'hFF6000;  6'd7:  c = 24'hFF7000;  6'd8:  c = 24'hFF8000;
            6'd9:  c = 24'hFF9000;  6'd10: c = 24'hFFA000;  6'd11: c = 24'hFFB000;
            6'd12: c = 24'hFFC000;  6'd13: c = 24'hFFD000;  6'd14: c = 24'hFFE000;
            6'd15: c = 24'hFFF000;  6'd16: c = 24'hFFFF00;  6'd17: c = 24'hE0FF00;
            6'd18: c = 24'hC0FF00;  6'd19: c = 24'hA0FF00;  6'd20: c = 24'h80FF00;
            6'd21: c = 24'h60FF00;  6'd22: c = 24'h40FF00;  6'd23: c = 24'h20FF00;
            6'd24: c = 24'h00FF00;  6'd25: c = 24'h00FF24;  6'd26: c = 24'h00FF49;
            6'd27: c = 24'h00FF6D;  6'd28: c = 24'h00FF92;  6'd29: c = 24'h00FFB6;
            6'd30: c = 24'h00FFDB;  6'd31: c = 24'h00FFFF;  6'd32: c = 24'h00E3FF;
            6'd33: c = 24'h00C6FF;  6'd34: c = 24'h00AAFF;  6'd35: c = 24'h008EFF;
            6'd36: c = 24'h0071FF;  6'd37: c = 24'h0055FF;  6'd38: c = 24'h0038FF;
            6'd39: c = 24'h001CFF;  6'd40: c = 24'h0000FF;  6'd41: c = 24'h2000FF;
            6'd42: c = 24'h4000FF;  6'd43: c = 24'h6000FF;  6'd44: c = 24'h8000FF;
            6'd45: c = 24'hA000FF;  6'd46: c = 24'hC000FF;  6'd47: c = 24'hE000FF;
            6'd48: c = 24'hFF00FF;  6'd49: c = 24'hFF20FF;  6'd50: c = 24'hFF40FF;
            6'd51: c = 24'hFF60FF;  6'd52: c = 24'hFF80FF;  6'd53: c = 24'hFFA0FF;
            6'd54: c = 24'hFFC0FF;  6'd55: c = 24'hFFE0FF;  6'd56: c = 24'hFFFFFF;
            6'd57: c = 24'hFFE0E0;  6'd58: c = 24'hFFC0C0;  6'd59: c = 24'hFFA0A0;
            6'd60: c = 24'hFF8080;  6'd61: c = 24'hFF6060;  6'd62: c = 24'hFF4040;
            6'd63: c = 24'hFF2020;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

@@ rtl/lvfp_palette.sv @@
// Palette store: one write port, one registered read port, per-entry valid bits.
// Depends on lvfp_pkg for the write struct and the default colour table.
module lvfp_palette #(
    parameter int PALETTE_DEPTH = lvfp_pkg::PALETTE_DEPTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  lvfp_pkg::pal_wr_t                 wr,
    input  logic                              rd_en,
    input  logic [lvfp_pkg::PAL_ADDR_W-1:0]   rd_addr,
    output logic [lvfp_pkg::COLOUR_W-1:0]     rd_data
);
    import lvfp_pkg::*;

    localparam int IW = $clog2(PALETTE_DEPTH);

    logic [COLOUR_W-1:0] mem [PALETTE_DEPTH];
    logic [PALETTE_DEPTH-1:0] vld_reg;
    logic [COLOUR_W-1:0] ram_q_reg;
    logic                vld_q_reg;
    logic [IW-1:0]       addr_q_reg;
    logic [COLOUR_W-1:0] dflt;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr[IW-1:0]] <= wr.data;
        end
        if (rd_en) begin
            ram_q_reg  <= mem[rd_addr[IW-1:0]];
            addr_q_reg <= rd_addr[IW-1:0];
        end
    end

    // An entry never written since reset reads as its power-on colour.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg   <= '0;
            vld_q_reg <= 1'b0;
        end else begin
            if (wr.en) begin
                vld_reg[wr.addr[IW-1:0]] <= 1'b1;
            end
            if (rd_en) begin
                vld_q_reg <= vld_reg[rd_addr[IW-1:0]];
            end
        end
    end

    always_comb begin
        if ({1'b0, addr_q_reg} < (IW+1)'(DEFAULT_COLOURS)) begin
            dflt = dflt_colour(addr_q_reg[5:0]);
        end else begin
            dflt = '0;
        end
        rd_data = vld_q_reg ? ram_q_reg : dflt;
    end

endmodule

@@ rtl/laser_vector_frame_parser_top.sv @@
// Top level of the laser vector frame parser: header, palette and point decoding,
// output staging. Depends on lvfp_pkg, lvfp_palette and the assertion macro header.
`include "laser_vector_frame_parser_top_macros.svh"

// The parser takes one stream byte per beat, one in every cycle while not stalled.
// Each frame opens with a 32-byte header (tag "ILDA", format code at byte 7,
// big-endian point count at bytes 24-25, projector at byte 30); point records
// or palette entries follow. A point result passes through the decode register,
// captured together with the palette read, and then the output register. The
// palette is a 256x24 memory with one registered read port; per-entry valid
// bits make the 64 default colours visible right after reset, so there is no
// clearing pass. Blanked points come out black, an index at or past the current
// palette size gives black, an empty frame gives an end-of-animation result,
// and a bad tag or format gives a sticky error after which bytes are still
// taken but ignored. Backpressure on the result side stalls the input only when
// both the decode and output registers are full.
module laser_vector_frame_parser_top #(
    parameter int PALETTE_DEPTH = lvfp_pkg::PALETTE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // [15:0] coord_x, [31:16] coord_y, [47:32] coord_z,
                                   // [55:48] red, [63:56] green, [71:64] blue,
                                   // [72] blanked, [80:73] projector_number,
                                   // [83:81] frame_format, [87:84] zero
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast    // last_in_frame
);
    import lvfp_pkg::*;

    localparam int WW = $clog2(PALETTE_DEPTH + 1);

    typedef enum logic [4:0] {
        ST_HEADER  = 5'b00001,
        ST_POINT   = 5'b00010,
        ST_PALETTE = 5'b00100,
        ST_ENDED   = 5'b01000,
        ST_ERROR   = 5'b10000
    } state_t;

    state_t        state_reg, state_next;
    logic [4:0]    hdr_pos_reg, hdr_pos_next;
    logic [3:0]    pt_pos_reg, pt_pos_next;
    logic [15:0]   cnt_reg, cnt_next;
    logic [7:0]    fmt_reg, fmt_next;
    logic [7:0]    proj_reg, proj_next;
    logic [23:0]   tag_reg, tag_next;
    logic [47:0]   coord_reg, coord_next;
    logic [15:0]   cbuf_reg, cbuf_next;     // palette R,G or true-colour G,B
    logic          blank_reg, blank_next;
    logic [8:0]    pal_size_reg, pal_size_next;
    logic [WW-1:0] wr_idx_reg, wr_idx_next;

    // Decode stage results.
    logic          res_valid;
    logic [1:0]    res_kind;
    logic [47:0]   res_coord;
    logic [23:0]   res_true;
    logic          res_indexed, res_hit, res_blank, res_last;
    logic [2:0]    res_fmt;
    logic [7:0]    res_proj;

    logic          mid_valid_reg;
    logic [1:0]    mid_kind_reg;
    logic [47:0]   mid_coord_reg;
    logic [23:0]   mid_true_reg;
    logic          mid_indexed_reg, mid_hit_reg, mid_blank_reg, mid_last_reg;
    logic [2:0]    mid_fmt_reg;
    logic [7:0]    mid_proj_reg;

    logic          out_valid_reg;
    logic [87:0]   out_data_reg;
    logic [1:0]    out_kind_reg;
    logic          out_last_reg;

    logic          acc, mid_adv;
    logic          three_d, indexed;
    logic [3:0]    cb;
    logic [15:0]   cnt_dec;
    pal_wr_t       pal_wr;
    logic [23:0]   pal_rd;
    logic [23:0]   colour;

    assign mid_adv  = !out_valid_reg || m_tready;
    assign s_tready = !mid_valid_reg || mid_adv;
    assign acc      = s_tvalid && s_tready;

    assign three_d = (fmt_reg == FMT_3D_IDX) || (fmt_reg == FMT_3D_TRUE);
    assign indexed = (fmt_reg == FMT_3D_IDX) || (fmt_reg == FMT_2D_IDX);
    assign cb      = three_d ? 4'd6 : 4'd4;
    assign cnt_dec = cnt_reg - 16'd1;

    always_comb begin
        state_next    = state_reg;
        hdr_pos_next  = hdr_pos_reg;
        pt_pos_next   = pt_pos_reg;
        cnt_next      = cnt_reg;
        fmt_next      = fmt_reg;
        proj_next     = proj_reg;
        tag_next      = tag_reg;
        coord_next    = coord_reg;
        cbuf_next     = cbuf_reg;
        blank_next    = blank_reg;
        pal_size_next = pal_size_reg;
        wr_idx_next   = wr_idx_reg;
        pal_wr        = '0;
        res_valid     = 1'b0;
        res_kind      = KIND_POINT;
        res_coord     = '0;
        res_true      = '0;
        res_indexed   = 1'b0;
        res_hit       = 1'b0;
        res_blank     = 1'b0;
        res_last      = 1'b0;
        res_fmt       = '0;
        res_proj      = '0;

        case (state_reg)
            ST_HEADER: begin
                hdr_pos_next = hdr_pos_reg + 5'd1;
                if (hdr_pos_reg < 5'd4) begin
                    tag_next = {tag_reg[15:0], s_tdata};
                    if (hdr_pos_reg == 5'd3 && {tag_reg, s_tdata} != TAG_WORD) begin
                        state_next = ST_ERROR;
                        res_valid  = 1'b1;
                        res_kind   = KIND_BAD_TAG;
                    end
                end else if (hdr_pos_reg == 5'd7) begin
                    fmt_next = s_tdata;
                end else if (hdr_pos_reg == 5'd24) begin
                    cnt_next = {s_tdata, 8'h00};
                end else if (hdr_pos_reg == 5'd25) begin
                    cnt_next = {cnt_reg[15:8], s_tdata};
                end else if (hdr_pos_reg == 5'd30) begin
                    proj_next = s_tdata;
                end else if (hdr_pos_reg == 5'd31) begin
                    hdr_pos_next = '0;
                    pt_pos_next  = '0;
                    blank_next   = 1'b0;
                    if (cnt_reg == 16'd0) begin
                        state_next = ST_ENDED;
                        res_valid  = 1'b1;
                        res_kind   = KIND_END;
                    end else if (fmt_reg == FMT_3D_IDX || fmt_reg == FMT_2D_IDX ||
                                 fmt_reg == FMT_3D_TRUE || fmt_reg == FMT_2D_TRUE) begin
                        state_next = ST_POINT;
                    end else if (fmt_reg == FMT_PALETTE) begin
                        state_next    = ST_PALETTE;
                        wr_idx_next   = '0;
                        pal_size_next = (cnt_reg > 16'(PALETTE_DEPTH)) ?
                                        9'(PALETTE_DEPTH) : cnt_reg[8:0];
                    end else begin
                        state_next = ST_ERROR;
                        res_valid  = 1'b1;
                        res_kind   = KIND_BAD_FMT;
                    end
                end
            end
            ST_PALETTE: begin
                if (pt_pos_reg < 4'd2) begin
                    cbuf_next   = {cbuf_reg[7:0], s_tdata};
                    pt_pos_next = pt_pos_reg + 4'd1;
                end else begin
                    // Entries past the store depth are read and dropped.
                    if (wr_idx_reg < WW'(PALETTE_DEPTH)) begin
                        pal_wr.en   = 1'b1;
                        pal_wr.addr = PAL_ADDR_W'(wr_idx_reg);
                        pal_wr.data = {cbuf_reg, s_tdata};
                        wr_idx_next = wr_idx_reg + WW'(1);
                    end
                    pt_pos_next = '0;
                    cnt_next    = cnt_dec;
                    if (cnt_dec == 16'd0) begin
                        state_next = ST_HEADER;
                    end
                end
            end
            ST_POINT: begin
                if (pt_pos_reg < cb) begin
                    // Coordinates arrive big-endian: even byte is the high half.
                    case (pt_pos_reg)
                        4'd0:    coord_next[15:8]  = s_tdata;
                        4'd1:    coord_next[7:0]   = s_tdata;
                        4'd2:    coord_next[31:24] = s_tdata;
                        4'd3:    coord_next[23:16] = s_tdata;
                        4'd4:    coord_next[47:40] = s_tdata;
                        default: coord_next[39:32] = s_tdata;
                    endcase
                    pt_pos_next = pt_pos_reg + 4'd1;
                end else if (pt_pos_reg == cb) begin
                    blank_next  = s_tdata[BLANK_BIT];
                    pt_pos_next = pt_pos_reg + 4'd1;
                end else if (!indexed && pt_pos_reg == cb + 4'd1) begin
                    cbuf_next[7:0] = s_tdata;            // blue
                    pt_pos_next    = pt_pos_reg + 4'd1;
                end else if (!indexed && pt_pos_reg == cb + 4'd2) begin
                    cbuf_next[15:8] = s_tdata;           // green
                    pt_pos_next     = pt_pos_reg + 4'd1;
                end else begin
                    res_valid   = 1'b1;
                    res_kind    = KIND_POINT;
                    res_coord   = {three_d ? coord_reg[47:32] : 16'd0, coord_reg[31:0]};
                    res_true    = {s_tdata, cbuf_reg[15:8], cbuf_reg[7:0]};
                    res_indexed = indexed;
                    res_hit     = ({1'b0, s_tdata} < pal_size_reg) &&
                                  ({1'b0, s_tdata} < 9'(PALETTE_DEPTH));
                    res_blank   = blank_reg;
                    res_last    = (cnt_dec == 16'd0);
                    res_fmt     = fmt_reg[2:0];
                    res_proj    = proj_reg;
                    cnt_next    = cnt_dec;
                    pt_pos_next = '0;
                    blank_next  = 1'b0;
                    if (cnt_dec == 16'd0) begin
                        state_next = ST_HEADER;
                    end
                end
            end
            default: begin
                // Ended or error: bytes are taken and ignored.
            end
        endcase
    end

    lvfp_palette #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (acc ? pal_wr : '0),
        .rd_en   (acc),
        .rd_addr (s_tdata),
        .rd_data (pal_rd)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_HEADER;
            hdr_pos_reg  <= '0;
            pt_pos_reg   <= '0;
            cnt_reg      <= '0;
            fmt_reg      <= '0;
            proj_reg     <= '0;
            tag_reg      <= '0;
            coord_reg    <= '0;
            cbuf_reg     <= '0;
            blank_reg    <= 1'b0;
            pal_size_reg <= 9'd64;
            wr_idx_reg   <= '0;
        end else if (acc) begin
            state_reg    <= state_next;
            hdr_pos_reg  <= hdr_pos_next;
            pt_pos_reg   <= pt_pos_next;
            cnt_reg      <= cnt_next;
            fmt_reg      <= fmt_next;
            proj_reg     <= proj_next;
            tag_reg      <= tag_next;
            coord_reg    <= coord_next;
            cbuf_reg     <= cbuf_next;
            blank_reg    <= blank_next;
            pal_size_reg <= pal_size_next;
            wr_idx_reg   <= wr_idx_next;
        end
    end

    // Decode register: captured together with the palette read.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mid_valid_reg <= 1'b0;
        end else if (acc) begin
            mid_valid_reg <= res_valid;
        end else if (mid_adv) begin
            mid_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (acc) begin
            mid_kind_reg    <= res_kind;
            mid_coord_reg   <= res_coord;
            mid_true_reg    <= res_true;
            mid_indexed_reg <= res_indexed;
            mid_hit_reg     <= res_hit;
            mid_blank_reg   <= res_blank;
            mid_last_reg    <= res_last;
            mid_fmt_reg     <= res_fmt;
            mid_proj_reg    <= res_proj;
        end
    end

    always_comb begin
        if (mid_blank_reg) begin
            colour = '0;
        end else if (mid_indexed_reg) begin
            colour = mid_hit_reg ? pal_rd : 24'd0;
        end else begin
            colour = mid_true_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (mid_adv) begin
            out_valid_reg <= mid_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (mid_adv) begin
            out_kind_reg <= mid_kind_reg;
            out_last_reg <= mid_last_reg;
            out_data_reg <= {4'd0, mid_fmt_reg, mid_proj_reg, mid_blank_reg,
                             colour[7:0], colour[15:8], colour[23:16], mid_coord_reg};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

    `LVFP_ASSERT_NOW(a_non_point_clean, m_tvalid && m_tuser != KIND_POINT,
        m_tdata == 88'd0 && !m_tlast, "non-point result carries payload")
    `LVFP_ASSERT_NOW(a_blank_black, m_tvalid && m_tdata[72],
        m_tdata[71:48] == 24'd0, "blanked point has nonzero colour")
    `LVFP_ASSERT_NEXT(a_error_sticky, state_reg == ST_ERROR,
        state_reg == ST_ERROR, "parser left the error state")

endmodule
